>>> sv/spq_pkg.sv
// Package for the sorted priority queue: payload words, operation and status codes,
// cell commands and the links between neighboring cells. No dependencies.
package spq_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_CHARS = 8;
   localparam int CNT_W     = $clog2(DEPTH + 1);

   // Only the top KEY_CHARS bytes of a key take part in the queue.
   localparam logic [63:0] KEY_MASK = ~({64{1'b1}} >> (8 * KEY_CHARS));

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_CHANGE  = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_EMPTY       = 3'd1;
   localparam logic [2:0] ST_MORE_URGENT = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
   localparam logic [2:0] ST_FULL        = 3'd4;

   localparam logic [2:0] CELL_HOLD   = 3'd0;
   localparam logic [2:0] CELL_INSERT = 3'd1;
   localparam logic [2:0] CELL_SHIFT  = 3'd2;
   localparam logic [2:0] CELL_REMOVE = 3'd3;
   localparam logic [2:0] CELL_CLEAR  = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic [63:0]        item_key;
      logic signed [15:0] item_priority;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [63:0]        removed_key;
      logic [63:0]        head_key;
      logic signed [15:0] head_priority;
      logic [4:0]         entry_count;
   } rsp_word_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic [2:0]         cmd;
      logic [63:0]        key;
      logic signed [15:0] pri;
   } cell_ctl_type;

   // What a cell hands to its right neighbor.
   typedef struct packed {
      logic [63:0]        key;
      logic signed [15:0] pri;
      logic               valid;
      logic               less;
      logic               found;
      logic signed [15:0] mpri;
   } cell_link_type;

   // What a cell hands to its left neighbor.
   typedef struct packed {
      logic [63:0]        key;
      logic signed [15:0] pri;
      logic               valid;
   } cell_data_type;

endpackage

>>> sv/spq_cell.sv
// One slot of the sorted queue: holds an entry and moves data to or from its neighbors.
// Depends on spq_pkg.
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cell_ctl_type  ctl,
   input  spq_pkg::cell_link_type link_in,
   input  spq_pkg::cell_data_type right_in,
   output spq_pkg::cell_link_type link_out,
   output spq_pkg::cell_data_type data_out
);
   import spq_pkg::*;

   logic [63:0]        key_ff, key_in;
   logic signed [15:0] pri_ff, pri_in;
   logic               valid_ff, valid_in;
   logic               less;
   logic               hit;

   always_comb begin
      less = valid_ff && (($signed(ctl.pri) < $signed(pri_ff)) ||
                          ((ctl.pri == pri_ff) && (ctl.key < key_ff)));
      hit  = valid_ff && (key_ff == ctl.key);

      link_out.key   = key_ff;
      link_out.pri   = pri_ff;
      link_out.valid = valid_ff;
      link_out.less  = less;
      link_out.found = link_in.found | hit;
      link_out.mpri  = link_in.found ? link_in.mpri : pri_ff;

      data_out.key   = key_ff;
      data_out.pri   = pri_ff;
      data_out.valid = valid_ff;

      key_in   = key_ff;
      pri_in   = pri_ff;
      valid_in = valid_ff;
      case (ctl.cmd)
         CELL_INSERT: begin
            // The new entry lands where the ripple starts; cells behind it move right.
            if (less || (!valid_ff && link_in.valid)) begin
               valid_in = 1'b1;
               if (link_in.less) begin
                  key_in = link_in.key;
                  pri_in = link_in.pri;
               end else begin
                  key_in = ctl.key;
                  pri_in = ctl.pri;
               end
            end
         end
         CELL_SHIFT: begin
            key_in   = right_in.key;
            pri_in   = right_in.pri;
            valid_in = right_in.valid;
         end
         CELL_REMOVE: begin
            // The first matching cell and all behind it close the gap.
            if (link_out.found) begin
               key_in   = right_in.key;
               pri_in   = right_in.pri;
               valid_in = right_in.valid;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pri_ff <= pri_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

>>> sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: request register, sequencer and the row of cells.
// Depends on spq_pkg and spq_cell.
//
//   channel | ports                          | direction | payload
//   req     | req_valid, req_ready, req_word | in        | spq_pkg::req_word_type
//   rsp     | rsp_valid, rsp_ready, rsp_word | out       | spq_pkg::rsp_word_type
//
// Enqueue, dequeue, clear and a change that does nothing go from the run state to the result
// stage; a successful change first runs probe, remove and reinsert through the cell row.
// One word is in work at a time: a new word is taken only once the last result is loaded.
// Synchronous reset empties the queue and drops any word in work.
// A result held by a stalled rsp side holds the next word in the result stage.
module sorted_priority_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spq_pkg::rsp_word_type rsp_word
);
   import spq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RUN    = 3'd1;
   localparam logic [2:0] S_REMOVE = 3'd2;
   localparam logic [2:0] S_INS    = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;
   localparam int         CNT_WIDE = CNT_W + 5;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         op_ff;
   logic [63:0]        key_ff;
   logic signed [15:0] pri_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [2:0]         status_ff, status_in;
   logic [63:0]        removed_ff, removed_in;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;
   logic [CNT_WIDE-1:0] cnt_ext;

   cell_ctl_type  ctl;
   cell_link_type link [DEPTH+1];
   cell_data_type data [DEPTH+1];
   logic          accept;
   logic          load_rsp;
   logic          full;
   logic          empty;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign full      = data[DEPTH-1].valid;
   assign empty     = !data[0].valid;
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign cnt_ext   = CNT_WIDE'(count_ff);

   // Left edge behaves as a valid entry that never moves; right edge is empty.
   assign link[0]  = '{key: '0, pri: '0, valid: 1'b1, less: 1'b0, found: 1'b0, mpri: '0};
   assign data[DEPTH] = '{key: '0, pri: '0, valid: 1'b0};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .link_in  (link[i]),
         .right_in (data[i+1]),
         .link_out (link[i+1]),
         .data_out (data[i])
      );
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      ctl.cmd    = CELL_HOLD;
      ctl.key    = key_ff;
      ctl.pri    = pri_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            status_in  = ST_OK;
            removed_in = '0;
            state_in   = S_DONE;
            case (op_ff)
               OP_ENQUEUE: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     ctl.cmd  = CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_DEQUEUE: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     ctl.cmd    = CELL_SHIFT;
                     removed_in = data[0].key;
                     count_in   = count_ff - CNT_W'(1);
                  end
               end
               OP_CHANGE: begin
                  // Probe only; the match chain settles which entry is the first one.
                  if (!link[DEPTH].found) begin
                     status_in = ST_NOT_FOUND;
                  end else if ($signed(link[DEPTH].mpri) <= $signed(pri_ff)) begin
                     status_in = ST_MORE_URGENT;
                  end else begin
                     state_in = S_REMOVE;
                  end
               end
               OP_CLEAR: begin
                  ctl.cmd  = CELL_CLEAR;
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_REMOVE: begin
            ctl.cmd  = CELL_REMOVE;
            count_in = count_ff - CNT_W'(1);
            state_in = S_INS;
         end
         S_INS: begin
            ctl.cmd  = CELL_INSERT;
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_word.op;
         key_ff <= req_word.item_key & KEY_MASK;
         pri_ff <= req_word.item_priority;
      end
      status_ff  <= status_in;
      removed_ff <= removed_in;
      if (load_rsp) begin
         rsp_word_ff.status        <= status_ff;
         rsp_word_ff.removed_key   <= removed_ff;
         rsp_word_ff.head_key      <= data[0].valid ? data[0].key : 64'd0;
         rsp_word_ff.head_priority <= data[0].valid ? data[0].pri : 16'sd0;
         rsp_word_ff.entry_count   <= cnt_ext[4:0];
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_matches_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == empty)
      else $error("entry count disagrees with the head cell");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      full |-> (count_ff == CNT_W'(DEPTH)))
      else $error("last cell holds an entry but the queue is not full");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RUN))
      else $error("accepted word did not start");

   a_remove_then_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REMOVE) |=> (state_ff == S_INS))
      else $error("priority change removed an entry without reinserting it");

endmodule

>>> bench/sorted_priority_queue_tb.sv
// Testbench for sorted_priority_queue: a scoreboard class that tracks the queue contents
// and checks every result word, plus tasks that drive requests with random gaps.
// Depends on spq_pkg and the RTL of sorted_priority_queue.
`timescale 1ns / 1ps

class spq_scoreboard;
   logic [63:0]        held_keys [spq_pkg::DEPTH];
   logic signed [15:0] held_pris [spq_pkg::DEPTH];
   int                 held_count;
   spq_pkg::rsp_word_type expected_words [$];
   int                 failures;

   function void take_out(int pos);
      int i;
      for (i = pos; i + 1 < held_count; i++) begin
         held_keys[i] = held_keys[i + 1];
         held_pris[i] = held_pris[i + 1];
      end
      held_count--;
   endfunction

   // Equal priority and key goes behind the entries already held.
   function void place_sorted(logic [63:0] key, logic signed [15:0] pri);
      int pos;
      int i;
      pos = 0;
      while (pos < held_count && !(pri < held_pris[pos] ||
             (pri == held_pris[pos] && key < held_keys[pos])))
         pos++;
      for (i = held_count; i > pos; i--) begin
         held_keys[i] = held_keys[i - 1];
         held_pris[i] = held_pris[i - 1];
      end
      held_keys[pos] = key;
      held_pris[pos] = pri;
      held_count++;
   endfunction

   function void note_request(spq_pkg::req_word_type w);
      spq_pkg::rsp_word_type want;
      logic [63:0]           key;
      int                    hit;
      int                    i;
      key = w.item_key & spq_pkg::KEY_MASK;
      want = '0;
      want.status = spq_pkg::ST_OK;
      case (w.op)
         spq_pkg::OP_ENQUEUE: begin
            if (held_count >= spq_pkg::DEPTH) want.status = spq_pkg::ST_FULL;
            else place_sorted(key, w.item_priority);
         end
         spq_pkg::OP_DEQUEUE: begin
            if (held_count == 0) begin
               want.status = spq_pkg::ST_EMPTY;
            end else begin
               want.removed_key = held_keys[0];
               take_out(0);
            end
         end
         spq_pkg::OP_CHANGE: begin
            want.status = spq_pkg::ST_NOT_FOUND;
            hit = -1;
            for (i = 0; i < held_count; i++)
               if (hit < 0 && held_keys[i] == key) hit = i;
            if (hit >= 0) begin
               if (held_pris[hit] <= w.item_priority) begin
                  want.status = spq_pkg::ST_MORE_URGENT;
               end else begin
                  take_out(hit);
                  place_sorted(key, w.item_priority);
                  want.status = spq_pkg::ST_OK;
               end
            end
         end
         default: held_count = 0;
      endcase
      if (held_count > 0) begin
         want.head_key      = held_keys[0];
         want.head_priority = held_pris[0];
      end
      want.entry_count = 5'(held_count);
      expected_words.push_back(want);
   endfunction

   function void flag(string what, spq_pkg::rsp_word_type want, spq_pkg::rsp_word_type got);
      failures++;
      if (failures <= 10)
         $display("%s: status %0d/%0d removed %h/%h head %h/%h pri %0d/%0d count %0d/%0d",
                  what, want.status, got.status, want.removed_key, got.removed_key,
                  want.head_key, got.head_key, want.head_priority, got.head_priority,
                  want.entry_count, got.entry_count);
   endfunction

   function void check_result(spq_pkg::rsp_word_type got);
      spq_pkg::rsp_word_type want;
      if (expected_words.size() == 0) begin
         flag("result word with no request waiting (expected/actual)", got, got);
      end else begin
         want = expected_words.pop_front();
         if (got.status !== want.status || got.removed_key !== want.removed_key ||
             got.head_key !== want.head_key || got.head_priority !== want.head_priority ||
             got.entry_count !== want.entry_count)
            flag("result word mismatch (expected/actual)", want, got);
      end
   endfunction

   function int pending();
      return expected_words.size();
   endfunction
endclass

module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int POOL_SIZE   = 12;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   spq_scoreboard sb;
   logic [63:0]   key_pool [POOL_SIZE];
   int            req_accepts = 0;
   int            words_sent  = 0;
   int            gap_after   = 0;
   bit            sender_idle = 1'b1;
   bit            no_gaps     = 1'b0;

   sorted_priority_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_word);
            req_accepts++;
         end
         if (rsp_valid && rsp_ready) sb.check_result(rsp_word);
      end
   end

   // Most gaps are short, a few are long.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] pack_text(string s);
      logic [63:0] k;
      int          i;
      k = '0;
      for (i = 0; i < 8; i++) k = {k[55:0], (i < s.len()) ? s[i] : 8'h00};
      return k;
   endfunction

   function automatic logic [63:0] pick_key();
      logic [63:0] k;
      int          r;
      int          i;
      int          chars;
      r = $urandom_range(0, 99);
      if (r < 55) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 80) return {$urandom, $urandom};
      // Short text, zero-padded at the low end.
      k = '0;
      chars = $urandom_range(1, 8);
      for (i = 0; i < 8; i++)
         k = {k[55:0], (i < chars) ? 8'($urandom_range(8'h41, 8'h7a)) : 8'h00};
      return k;
   endfunction

   function automatic int pick_priority();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return int'($urandom_range(0, 8)) - 4;
      if (r < 85) return int'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
         0: return -32768;
         1: return 32767;
         2: return -1;
         default: return 0;
      endcase
   endfunction

   task automatic send_op(logic [1:0] op, logic [63:0] key, int pri);
      req_word_type w;
      int           seen;
      w.op            = op;
      w.item_key      = key;
      w.item_priority = 16'(pri);
      repeat (gap_after) @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      seen = req_accepts;
      do @(negedge clock); while (req_accepts == seen);
      words_sent++;
      gap_after   = gap_length();
      sender_idle = (gap_after > 0);
      if (sender_idle) req_valid <= 1'b0;
   endtask

   task automatic hold_sender();
      if (!sender_idle) begin
         req_valid  <= 1'b0;
         sender_idle = 1'b1;
      end
      gap_after = 0;
   endtask

   task automatic wait_for_results();
      hold_sender();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic random_change();
      logic [63:0] key;
      if (sb.held_count > 0 && $urandom_range(0, 2) != 0)
         key = sb.held_keys[$urandom_range(0, sb.held_count - 1)];
      else
         key = pick_key();
      send_op(OP_CHANGE, key, pick_priority());
   endtask

   task automatic run_directed();
      send_op(OP_DEQUEUE, '0, 0);                  // dequeue on an empty queue
      send_op(OP_CHANGE, pack_text("JOB"), 1);     // change on an empty queue
      send_op(OP_ENQUEUE, '1, 32767);
      send_op(OP_ENQUEUE, '0, -32768);
      send_op(OP_ENQUEUE, pack_text("JOB"), 5);
      send_op(OP_ENQUEUE, pack_text("JOB"), 5);    // exact duplicate goes behind
      send_op(OP_ENQUEUE, pack_text("ALPHA"), 5);  // priority tie broken by key
      send_op(OP_CHANGE, pack_text("JOB"), 5);     // same priority is already urgent enough
      send_op(OP_CHANGE, pack_text("JOB"), 9);
      send_op(OP_CHANGE, pack_text("NOPE"), 0);
      send_op(OP_CHANGE, '0, -32768);
      send_op(OP_CHANGE, pack_text("JOB"), -32768); // first match moves up
      send_op(OP_CHANGE, '1, -32768);               // last entry moves up
      send_op(OP_DEQUEUE, '0, 0);
      send_op(OP_CLEAR, '0, 0);
      send_op(OP_ENQUEUE, pack_text("B"), 3);
      send_op(OP_ENQUEUE, pack_text("A"), 4);
      send_op(OP_CHANGE, pack_text("B"), 1);       // the front entry itself changes
      send_op(OP_DEQUEUE, '0, 0);
      send_op(OP_DEQUEUE, '0, 0);
      send_op(OP_DEQUEUE, '0, 0);
      send_op(OP_CLEAR, '0, 0);                    // clear with nothing held
      send_op(OP_ENQUEUE, {$urandom, $urandom}, -1);
      send_op(OP_CLEAR, '0, 0);
   endtask

   task automatic run_random(int goal);
      int kind;
      int n;
      int i;
      int r;
      bit first;
      first = 1'b1;
      while (words_sent < goal) begin
         kind = first ? 0 : $urandom_range(0, 9);
         if (first || $urandom_range(0, 3) == 0) wait_for_results();
         first   = 1'b0;
         no_gaps = ($urandom_range(0, 3) == 0);
         if (kind <= 2) begin
            // Fill past the top so that full is reached and overflow is seen.
            n = $urandom_range(18, 24);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 9) == 0) random_change();
               else send_op(OP_ENQUEUE, pick_key(), pick_priority());
            end
         end else if (kind <= 4) begin
            while (sb.held_count > 0) begin
               if ($urandom_range(0, 4) == 0) random_change();
               else send_op(OP_DEQUEUE, pick_key(), pick_priority());
            end
            send_op(OP_DEQUEUE, pick_key(), pick_priority());
            random_change();
         end else if (kind <= 8) begin
            n = $urandom_range(20, 40);
            for (i = 0; i < n; i++) begin
               r = $urandom_range(0, 99);
               if (r < 40) send_op(OP_ENQUEUE, pick_key(), pick_priority());
               else if (r < 65) send_op(OP_DEQUEUE, pick_key(), pick_priority());
               else if (r < 95) random_change();
               else send_op(OP_CLEAR, pick_key(), pick_priority());
            end
         end else begin
            n = $urandom_range(5, 12);
            for (i = 0; i < n; i++)
               send_op(2'($urandom_range(0, 3)), {$urandom, $urandom},
                       int'($urandom_range(0, 65535)));
         end
      end
   endtask

   // Result side: random stalls, with steady stretches when no_gaps is set.
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = gap_length();
         if (n == 0) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   // Ends the run when no word moves on either side for too long.
   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int i;
      sb        = new;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      for (i = 0; i < POOL_SIZE; i++)
         key_pool[i] = (i < 6) ? pack_text($sformatf("TASK%0d", i)) : {$urandom, $urandom};
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      run_random(words_sent + 1030);
      wait_for_results();
      repeat (12) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
bench/sorted_priority_queue_tb.sv
